FILE: rtl/thfp_pkg.sv
// ----------------------------------------------------------------------------
// thfp_pkg
// Shared types and constants for the header-transport frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package thfp_pkg;

    localparam int unsigned FIXED_LEN      = 14;
    localparam int unsigned FIXED_NO_LEN   = 10;
    localparam int unsigned MIN_FRAME      = 14;
    localparam int unsigned MAX_HDR_BYTES  = 65536;
    localparam int unsigned VARINT_MAX     = 5;
    localparam int unsigned RES_DEPTH      = 4;
    localparam int unsigned CFG_IDX_W      = 1;

    localparam logic [30:0] MAX_FRAME_RESET = 31'd5242880;
    localparam logic [15:0] MAGIC_RESET     = 16'd4095;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC     = 1'd1;

    typedef enum logic [2:0] {
        KIND_KEY  = 3'd0,
        KIND_VAL  = 3'd1,
        KIND_PAIR = 3'd2,
        KIND_INFO = 3'd3,
        KIND_PAY  = 3'd4,
        KIND_ERR  = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        ERR_FRAME_SIZE   = 4'd0,
        ERR_MAGIC        = 4'd1,
        ERR_HDR_SIZE     = 4'd2,
        ERR_HDR_SMALL    = 4'd3,
        ERR_VARINT_LONG  = 4'd4,
        ERR_EXCEEDS_I16  = 4'd5,
        ERR_PROTOCOL     = 4'd6,
        ERR_XFORM_COUNT  = 4'd7,
        ERR_HDR_COUNT    = 4'd8,
        ERR_HDR_VS_FRAME = 4'd9,
        ERR_NEG_STRLEN   = 4'd10
    } err_code_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic               string_last;
        logic signed [31:0] sequence_id;
        logic [30:0]        payload_size;
        logic               protocol;
        logic               transform_unknown;
        logic signed [31:0] transform_id;
        logic [3:0]         error_code;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/thfp_in_if.sv
// ----------------------------------------------------------------------------
// thfp_in_if
// Byte stream channel into the parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface thfp_in_if import thfp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/thfp_out_if.sv
// ----------------------------------------------------------------------------
// thfp_out_if
// Result channel out of the parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface thfp_out_if import thfp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic [7:0]         out_byte;
    logic               string_last;
    logic signed [31:0] sequence_id;
    logic [30:0]        payload_size;
    logic               protocol;
    logic               transform_unknown;
    logic signed [31:0] transform_id;
    logic [3:0]         error_code;

    modport source (output valid, output kind, output out_byte, output string_last,
                    output sequence_id, output payload_size, output protocol,
                    output transform_unknown, output transform_id, output error_code,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input string_last,
                    input sequence_id, input payload_size, input protocol,
                    input transform_unknown, input transform_id, input error_code,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/thfp_cfg_if.sv
// ----------------------------------------------------------------------------
// thfp_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface thfp_cfg_if import thfp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/thfp_result_fifo.sv
// ----------------------------------------------------------------------------
// thfp_result_fifo
// Small result queue that takes up to two items per cycle and gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module thfp_result_fifo import thfp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic [1:0] push_cnt,
    input  result_t   push0,
    input  result_t   push1,
    input  logic      pop,
    output logic      head_valid,
    output result_t   head,
    output logic      room_for_two
);

    localparam int unsigned PTR_W = $clog2(RES_DEPTH);

    result_t             mem_reg [RES_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W:0]      count_reg;
    logic                do_pop;

    assign head_valid   = (count_reg != '0);
    assign head         = mem_reg[rd_ptr_reg];
    assign do_pop       = pop && head_valid;
    assign room_for_two = (count_reg <= (PTR_W+1)'(RES_DEPTH - 2));

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (PTR_W+1)'(push_cnt) - (PTR_W+1)'(do_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/thrift_header_frame_parser_top.sv
// ----------------------------------------------------------------------------
// thrift_header_frame_parser_top
// Header-transport frame parser: one stream byte in, key/value/payload bytes,
// pair ends, frame info and errors out.
// ----------------------------------------------------------------------------
//
//  Channel     Direction  Payload
//  data_in     in         data_byte (8)
//  result_out  out        kind, out_byte, string_last, sequence_id,
//                         payload_size, protocol, transform_unknown,
//                         transform_id, error_code
//  cfg         in         index (1), data (32): 0 max_frame_size, 1 magic_word
//
// One byte is accepted per cycle. Each byte is parsed in the cycle it is
// accepted and its zero, one or two result items land in a four-entry queue.
// The input stalls only when the queue has fewer than two free entries, so
// the rate is one byte per cycle as long as the result side keeps draining.
// Reset clears the parse state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module thrift_header_frame_parser_top import thfp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    thfp_in_if.sink     data_in,
    thfp_out_if.source  result_out,
    thfp_cfg_if.sink    cfg
);

    typedef enum logic [3:0] {
        PH_FIXED, PH_PROTO, PH_NXFORM, PH_XFORM_ID, PH_INFO_ID, PH_HCOUNT,
        PH_KEYLEN, PH_KEY, PH_VALLEN, PH_VAL, PH_SKIP, PH_PAYLOAD
    } phase_t;

    // What must happen after the byte's own work, resolved in model order.
    typedef enum logic [2:0] {
        CT_NONE, CT_START, CT_FINISH, CT_SKIP, CT_BEGIN_INFO, CT_NEXT_PAIR,
        CT_PAIR_DONE
    } cont_t;

    // Configuration registers.
    logic [30:0] max_frame_reg;
    logic [15:0] magic_reg;

    // Parse state.
    phase_t      phase_reg,   phase_next;
    logic [3:0]  fcnt_reg,    fcnt_next;
    logic [31:0] flen_reg,    flen_next;
    logic [15:0] mshift_reg,  mshift_next;
    logic [31:0] seq_reg,     seq_next;
    logic [16:0] hdr_reg,     hdr_next;
    logic [31:0] vacc_reg,    vacc_next;
    logic [2:0]  vbytes_reg,  vbytes_next;
    logic [31:0] items_reg,   items_next;
    logic [14:0] str_reg,     str_next;
    logic        proto_reg,   proto_next;
    logic        xseen_reg,   xseen_next;
    logic [31:0] xval_reg,    xval_next;
    logic [30:0] pay_reg,     pay_next;
    logic        err_reg,     err_next;

    logic        accept;
    logic        emit_data;
    logic        emit_tail;
    result_t     data_res;
    result_t     tail_res;
    logic [1:0]  push_cnt;
    result_t     push0;
    result_t     push1;
    logic        head_valid;
    result_t     head;
    logic        room_for_two;

    assign data_in.ready = room_for_two;
    assign accept        = data_in.valid && data_in.ready;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_reg <= MAX_FRAME_RESET;
            magic_reg     <= MAGIC_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MAX_FRAME: max_frame_reg <= cfg.data[30:0];
                CFG_MAGIC:     magic_reg     <= cfg.data[15:0];
                default:       ;
            endcase
        end
    end

    // The whole byte step. Blocking assignments follow the order in which the
    // stream format is defined; the tail slot holds a pair end, frame info or
    // error, and a later frame info or error replaces a pending pair end.
    always_comb
    begin
        logic [7:0]  b;
        logic [3:0]  c;
        logic [31:0] v;
        logic        gt16;
        cont_t       cont;
        phase_t      start_ph;
        logic [16:0] hs;

        b = data_in.data_byte;
        c = fcnt_reg;
        v = '0;
        gt16 = 1'b0;
        cont = CT_NONE;
        start_ph = PH_PROTO;
        hs = '0;

        phase_next  = phase_reg;
        fcnt_next   = fcnt_reg;
        flen_next   = flen_reg;
        mshift_next = mshift_reg;
        seq_next    = seq_reg;
        hdr_next    = hdr_reg;
        vacc_next   = vacc_reg;
        vbytes_next = vbytes_reg;
        items_next  = items_reg;
        str_next    = str_reg;
        proto_next  = proto_reg;
        xseen_next  = xseen_reg;
        xval_next   = xval_reg;
        pay_next    = pay_reg;
        err_next    = err_reg;

        emit_data = 1'b0;
        emit_tail = 1'b0;
        data_res  = '0;
        tail_res  = '0;

        if (accept && !err_reg)
        begin
            case (phase_reg)
                PH_PROTO, PH_NXFORM, PH_XFORM_ID, PH_INFO_ID, PH_HCOUNT,
                PH_KEYLEN, PH_VALLEN:
                begin
                    if (hdr_reg != '0)
                    begin
                        hdr_next = hdr_reg - 17'd1;
                    end
                    case (vbytes_reg)
                        3'd0:    vacc_next = vacc_reg | {25'd0, b[6:0]};
                        3'd1:    vacc_next = vacc_reg | {18'd0, b[6:0], 7'd0};
                        3'd2:    vacc_next = vacc_reg | {11'd0, b[6:0], 14'd0};
                        3'd3:    vacc_next = vacc_reg | {4'd0, b[6:0], 21'd0};
                        3'd4:    vacc_next = vacc_reg | {b[3:0], 28'd0};
                        default: vacc_next = vacc_reg;
                    endcase
                    vbytes_next = vbytes_reg + 3'd1;
                    v = vacc_next;
                    gt16 = !v[31] && (v[30:15] != '0);
                    if (b[7])
                    begin
                        if (vbytes_next >= 3'(VARINT_MAX))
                        begin
                            err_next = 1'b1;
                            emit_tail = 1'b1;
                            tail_res.kind = KIND_ERR;
                            tail_res.error_code = ERR_VARINT_LONG;
                        end
                        else if (hdr_next == '0)
                        begin
                            err_next = 1'b1;
                            emit_tail = 1'b1;
                            tail_res.kind = KIND_ERR;
                            tail_res.error_code = ERR_HDR_SMALL;
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_PROTO:
                            begin
                                if (gt16)
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_EXCEEDS_I16;
                                end
                                else if (v[15:0] == 16'd0 || v[15:0] == 16'd2)
                                begin
                                    proto_next = v[1];
                                    cont = CT_START;
                                    start_ph = PH_NXFORM;
                                end
                                else
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_PROTOCOL;
                                end
                            end
                            PH_NXFORM:
                            begin
                                if (gt16)
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_EXCEEDS_I16;
                                end
                                else if (v[15])
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_XFORM_COUNT;
                                end
                                else if (v[14:0] != '0)
                                begin
                                    cont = CT_START;
                                    start_ph = PH_XFORM_ID;
                                end
                                else
                                begin
                                    cont = CT_BEGIN_INFO;
                                end
                            end
                            PH_XFORM_ID:
                            begin
                                xseen_next = 1'b1;
                                xval_next = v;
                                cont = CT_SKIP;
                            end
                            PH_INFO_ID:
                            begin
                                if (v != 32'd1)
                                begin
                                    cont = CT_SKIP;
                                end
                                else
                                begin
                                    cont = CT_START;
                                    start_ph = PH_HCOUNT;
                                end
                            end
                            PH_HCOUNT:
                            begin
                                if (v[31])
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_HDR_COUNT;
                                end
                                else
                                begin
                                    items_next = v;
                                    cont = CT_NEXT_PAIR;
                                end
                            end
                            default:
                            begin
                                // Key or value length.
                                if (gt16)
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_EXCEEDS_I16;
                                end
                                else if (v[15])
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_NEG_STRLEN;
                                end
                                else if ({2'd0, v[14:0]} > hdr_next)
                                begin
                                    err_next = 1'b1;
                                    emit_tail = 1'b1;
                                    tail_res.kind = KIND_ERR;
                                    tail_res.error_code = ERR_HDR_SMALL;
                                end
                                else if (v[14:0] == '0)
                                begin
                                    if (phase_reg == PH_KEYLEN)
                                    begin
                                        cont = CT_START;
                                        start_ph = PH_VALLEN;
                                    end
                                    else
                                    begin
                                        cont = CT_PAIR_DONE;
                                    end
                                end
                                else
                                begin
                                    str_next = v[14:0];
                                    phase_next = (phase_reg == PH_KEYLEN) ? PH_KEY : PH_VAL;
                                end
                            end
                        endcase
                    end
                end
                PH_KEY, PH_VAL:
                begin
                    if (hdr_reg != '0)
                    begin
                        hdr_next = hdr_reg - 17'd1;
                    end
                    if (str_reg != '0)
                    begin
                        str_next = str_reg - 15'd1;
                    end
                    emit_data = 1'b1;
                    data_res.kind = (phase_reg == PH_KEY) ? KIND_KEY : KIND_VAL;
                    data_res.out_byte = b;
                    data_res.string_last = (str_next == '0);
                    if (str_next == '0)
                    begin
                        if (phase_reg == PH_KEY)
                        begin
                            cont = CT_START;
                            start_ph = PH_VALLEN;
                        end
                        else
                        begin
                            cont = CT_PAIR_DONE;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (hdr_reg != '0)
                    begin
                        hdr_next = hdr_reg - 17'd1;
                    end
                    if (hdr_next == '0)
                    begin
                        cont = CT_FINISH;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pay_reg != '0)
                    begin
                        pay_next = pay_reg - 31'd1;
                    end
                    emit_data = 1'b1;
                    data_res.kind = KIND_PAY;
                    data_res.out_byte = b;
                    data_res.string_last = (pay_next == '0);
                    if (pay_next == '0)
                    begin
                        phase_next = PH_FIXED;
                        fcnt_next = '0;
                    end
                end
                default:
                begin
                    // Fixed preamble: size, magic, flags, sequence id, header words.
                    fcnt_next = c + 4'd1;
                    if (c < 4'd4)
                    begin
                        flen_next = {flen_reg[23:0], b};
                        if (c == 4'd3 && (flen_next[31] || flen_next < 32'(MIN_FRAME) ||
                                          flen_next > {1'b0, max_frame_reg}))
                        begin
                            err_next = 1'b1;
                            emit_tail = 1'b1;
                            tail_res.kind = KIND_ERR;
                            tail_res.error_code = ERR_FRAME_SIZE;
                        end
                    end
                    else if (c < 4'd6)
                    begin
                        mshift_next = {mshift_reg[7:0], b};
                        if (c == 4'd5 && mshift_next != magic_reg)
                        begin
                            err_next = 1'b1;
                            emit_tail = 1'b1;
                            tail_res.kind = KIND_ERR;
                            tail_res.error_code = ERR_MAGIC;
                        end
                    end
                    else if (c < 4'd8)
                    begin
                        // Flag bytes carry nothing the parser needs.
                    end
                    else if (c < 4'd12)
                    begin
                        seq_next = {seq_reg[23:0], b};
                    end
                    else
                    begin
                        mshift_next = {mshift_reg[7:0], b};
                        if (c == 4'(FIXED_LEN - 1))
                        begin
                            fcnt_next = '0;
                            hs = {mshift_next[14:0], 2'b00};
                            err_next = 1'b1;
                            emit_tail = 1'b1;
                            tail_res.kind = KIND_ERR;
                            if (mshift_next[15] || hs > 17'(MAX_HDR_BYTES))
                            begin
                                tail_res.error_code = ERR_HDR_SIZE;
                            end
                            else if (hs == '0)
                            begin
                                tail_res.error_code = ERR_HDR_SMALL;
                            end
                            else if ({15'd0, hs} > flen_reg - 32'(FIXED_NO_LEN))
                            begin
                                tail_res.error_code = ERR_HDR_VS_FRAME;
                            end
                            else
                            begin
                                err_next = 1'b0;
                                emit_tail = 1'b0;
                                tail_res = '0;
                                hdr_next = hs;
                                pay_next = 31'(flen_reg - 32'(FIXED_NO_LEN) - {15'd0, hs});
                                cont = CT_START;
                                start_ph = PH_PROTO;
                            end
                        end
                    end
                end
            endcase

            // Follow-on steps, in the order the format nests them.
            if (cont == CT_PAIR_DONE)
            begin
                emit_tail = 1'b1;
                tail_res = '0;
                tail_res.kind = KIND_PAIR;
                items_next = items_next - 32'd1;
                cont = CT_NEXT_PAIR;
            end
            if (cont == CT_NEXT_PAIR)
            begin
                if (items_next == '0)
                begin
                    cont = CT_BEGIN_INFO;
                end
                else
                begin
                    cont = CT_START;
                    start_ph = PH_KEYLEN;
                end
            end
            if (cont == CT_BEGIN_INFO)
            begin
                if (hdr_next == '0)
                begin
                    cont = CT_FINISH;
                end
                else
                begin
                    cont = CT_START;
                    start_ph = PH_INFO_ID;
                end
            end
            if (cont == CT_SKIP)
            begin
                if (hdr_next == '0)
                begin
                    cont = CT_FINISH;
                end
                else
                begin
                    phase_next = PH_SKIP;
                end
            end
            if (cont == CT_START)
            begin
                phase_next = start_ph;
                vacc_next = '0;
                vbytes_next = '0;
                if (hdr_next == '0)
                begin
                    err_next = 1'b1;
                    emit_tail = 1'b1;
                    tail_res = '0;
                    tail_res.kind = KIND_ERR;
                    tail_res.error_code = ERR_HDR_SMALL;
                end
            end
            if (cont == CT_FINISH)
            begin
                emit_tail = 1'b1;
                tail_res = '0;
                tail_res.kind = KIND_INFO;
                tail_res.sequence_id = seq_next;
                tail_res.payload_size = pay_next;
                tail_res.protocol = proto_next;
                tail_res.transform_unknown = xseen_next;
                tail_res.transform_id = xseen_next ? xval_next : '0;
                xseen_next = 1'b0;
                xval_next = '0;
                if (pay_next == '0)
                begin
                    phase_next = PH_FIXED;
                    fcnt_next = '0;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIXED;
            fcnt_reg   <= '0;
            flen_reg   <= '0;
            mshift_reg <= '0;
            seq_reg    <= '0;
            hdr_reg    <= '0;
            vacc_reg   <= '0;
            vbytes_reg <= '0;
            items_reg  <= '0;
            str_reg    <= '0;
            proto_reg  <= 1'b0;
            xseen_reg  <= 1'b0;
            xval_reg   <= '0;
            pay_reg    <= '0;
            err_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            fcnt_reg   <= fcnt_next;
            flen_reg   <= flen_next;
            mshift_reg <= mshift_next;
            seq_reg    <= seq_next;
            hdr_reg    <= hdr_next;
            vacc_reg   <= vacc_next;
            vbytes_reg <= vbytes_next;
            items_reg  <= items_next;
            str_reg    <= str_next;
            proto_reg  <= proto_next;
            xseen_reg  <= xseen_next;
            xval_reg   <= xval_next;
            pay_reg    <= pay_next;
            err_reg    <= err_next;
        end
    end

    // A data byte always comes first; the tail item follows it.
    always_comb
    begin
        push_cnt = 2'(emit_data) + 2'(emit_tail);
        push0 = emit_data ? data_res : tail_res;
        push1 = tail_res;
    end

    thfp_result_fifo u_result_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push0        (push0),
        .push1        (push1),
        .pop          (result_out.ready),
        .head_valid   (head_valid),
        .head         (head),
        .room_for_two (room_for_two)
    );

    assign result_out.valid             = head_valid;
    assign result_out.kind              = head.kind;
    assign result_out.out_byte          = head.out_byte;
    assign result_out.string_last       = head.string_last;
    assign result_out.sequence_id       = head.sequence_id;
    assign result_out.payload_size      = head.payload_size;
    assign result_out.protocol          = head.protocol;
    assign result_out.transform_unknown = head.transform_unknown;
    assign result_out.transform_id      = head.transform_id;
    assign result_out.error_code        = head.error_code;

endmodule

`default_nettype wire
